// ----- design/bpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Bucket priority queue package
// Shared constants, field layout, codes and types for the queue core.
// ----------------------------------------------------------------------------
package bpq_pkg;

    // Default sizing of the core.
    localparam int LEVELS_DEF     = 16;
    localparam int CAPACITY_DEF   = 256;
    localparam int ELEM_WIDTH_DEF = 32;

    // Fixed field widths on the stream ports.
    localparam int ELEM_FW   = 32;
    localparam int PRIO_FW   = 4;
    localparam int COUNT_FW  = 9;
    localparam int STATUS_FW = 2;

    // Stream data widths, padded to whole bytes.
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    // Bit positions of the result fields inside m_tdata.
    localparam int M_PRIO_LSB  = ELEM_FW;
    localparam int M_COUNT_LSB = M_PRIO_LSB + PRIO_FW;
    localparam int M_EMPTY_BIT = M_COUNT_LSB + COUNT_FW;
    localparam int M_PAD_W     = M_TDATA_W - M_EMPTY_BIT - 1;

    // Reset value of the lowest accepted level.
    localparam logic [PRIO_FW-1:0] LOWEST_LEVEL_RESET = 4'd15;

    // Operation kinds carried in s_tuser.
    localparam logic MODE_ENQ = 1'b0;
    localparam logic MODE_DEQ = 1'b1;

    // Result status codes carried in m_tuser.
    typedef enum logic [STATUS_FW-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // Commands broadcast to the level cells.
    typedef enum logic [1:0] {
        OP_NONE     = 2'd0,
        OP_PUSH     = 2'd1,
        OP_POP_LAST = 2'd2,
        OP_SET_HEAD = 2'd3
    } cell_op_t;

endpackage

// ----- design/bpq_level_cell.sv -----
// ----------------------------------------------------------------------------
// Bucket priority queue level cell
// Holds the list head, list tail and occupancy of one priority level and
// takes part in the head-search chain and the level-lookup chain.
// ----------------------------------------------------------------------------
module bpq_level_cell #(
    parameter int IDX_W    = 8,
    parameter int LW       = 4,
    parameter int LEVEL_ID = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    // Command broadcast from the sequencer
    input  bpq_pkg::cell_op_t op_in,
    input  logic [LW-1:0]    op_level,
    input  logic [IDX_W-1:0] op_ptr,
    // Head-search chain: lowest non-empty level seen so far
    input  logic             found_in,
    input  logic [LW-1:0]    level_in,
    input  logic [IDX_W-1:0] head_in,
    input  logic [IDX_W-1:0] tail_in,
    output logic             found_out,
    output logic [LW-1:0]    level_out,
    output logic [IDX_W-1:0] head_out,
    output logic [IDX_W-1:0] tail_out,
    // Lookup chain: occupancy and tail of the addressed level
    input  logic [LW-1:0]    q_level,
    input  logic             q_ne_in,
    input  logic [IDX_W-1:0] q_tail_in,
    output logic             q_ne_out,
    output logic [IDX_W-1:0] q_tail_out
);

    localparam logic [LW-1:0] MY_LEVEL = LW'(LEVEL_ID);

    logic [IDX_W-1:0] head_reg, head_next;
    logic [IDX_W-1:0] tail_reg, tail_next;
    logic             ne_reg, ne_next;
    logic             hit;

    assign hit = (op_level == MY_LEVEL);

    // Apply the command when it addresses this level.
    always_comb begin
        head_next = head_reg;
        tail_next = tail_reg;
        ne_next   = ne_reg;
        case (op_in)
            bpq_pkg::OP_PUSH: begin
                if (hit) begin
                    tail_next = op_ptr;
                    if (!ne_reg) begin
                        head_next = op_ptr;
                        ne_next   = 1'b1;
                    end
                end
            end
            bpq_pkg::OP_POP_LAST: begin
                if (hit) begin
                    ne_next = 1'b0;
                end
            end
            bpq_pkg::OP_SET_HEAD: begin
                if (hit) begin
                    head_next = op_ptr;
                end
            end
            default: begin
                head_next = head_reg;
            end
        endcase
    end

    // Pointers are written before they are ever read, so only the flag resets.
    always_ff @(posedge aclk) begin
        head_reg <= head_next;
        tail_reg <= tail_next;
        if (!aresetn) begin
            ne_reg <= 1'b0;
        end else begin
            ne_reg <= ne_next;
        end
    end

    // A lower level that is occupied wins; otherwise this level offers itself.
    always_comb begin
        found_out = found_in | ne_reg;
        if (found_in) begin
            level_out = level_in;
            head_out  = head_in;
            tail_out  = tail_in;
        end else begin
            level_out = MY_LEVEL;
            head_out  = head_reg;
            tail_out  = tail_reg;
        end
    end

    // The addressed level replaces whatever came down the lookup chain.
    always_comb begin
        if (q_level == MY_LEVEL) begin
            q_ne_out   = ne_reg;
            q_tail_out = tail_reg;
        end else begin
            q_ne_out   = q_ne_in;
            q_tail_out = q_tail_in;
        end
    end

endmodule

// ----- design/bpq_entry_store.sv -----
// ----------------------------------------------------------------------------
// Bucket priority queue entry store
// Element values and next-entry links of all entries, each in a memory with
// one write port and one registered read port.
// ----------------------------------------------------------------------------
module bpq_entry_store #(
    parameter int DEPTH      = 256,
    parameter int IDX_W      = 8,
    parameter int ELEM_WIDTH = 32
) (
    input  logic                  aclk,
    input  logic                  value_we,
    input  logic [IDX_W-1:0]      value_waddr,
    input  logic [ELEM_WIDTH-1:0] value_wdata,
    input  logic                  value_re,
    input  logic [IDX_W-1:0]      value_raddr,
    output logic [ELEM_WIDTH-1:0] value_rdata,
    input  logic                  link_we,
    input  logic [IDX_W-1:0]      link_waddr,
    input  logic [IDX_W-1:0]      link_wdata,
    input  logic                  link_re,
    input  logic [IDX_W-1:0]      link_raddr,
    output logic [IDX_W-1:0]      link_rdata
);

    logic [ELEM_WIDTH-1:0] value_mem [DEPTH];
    logic [IDX_W-1:0]      link_mem  [DEPTH];
    logic [ELEM_WIDTH-1:0] value_rd_reg;
    logic [IDX_W-1:0]      link_rd_reg;

    // Value memory; a read in the same cycle as a write returns the old data.
    always_ff @(posedge aclk) begin
        if (value_we) begin
            value_mem[value_waddr] <= value_wdata;
        end
        if (value_re) begin
            value_rd_reg <= value_mem[value_raddr];
        end
    end

    // Link memory, same read-before-write behavior.
    always_ff @(posedge aclk) begin
        if (link_we) begin
            link_mem[link_waddr] <= link_wdata;
        end
        if (link_re) begin
            link_rd_reg <= link_mem[link_raddr];
        end
    end

    assign value_rdata = value_rd_reg;
    assign link_rdata  = link_rd_reg;

endmodule

// ----- design/bucket_priority_queue_core.sv -----
// An accepted operation passes S_EXEC, S_READ and S_OUT, and its result is then
// loaded into the output register (rejected operations, enqueue onto an empty
// level, dequeue of a level's last entry); enqueue behind a tail adds S_LINK and
// a dequeue that must fetch the next link adds S_DQN. A new operation is taken
// only in S_IDLE, once the previous result has been loaded; S_OUT waits on m_tready.
// Reset (aresetn low, synchronous) empties all levels and the entry store.
// ----------------------------------------------------------------------------
// Bucket priority queue core
// One FIFO per priority level in a shared linked entry store; level 0 is
// served first. A row of level cells tracks the lists and finds the head.
// ----------------------------------------------------------------------------
module bucket_priority_queue_core #(
    parameter int LEVELS     = bpq_pkg::LEVELS_DEF,
    parameter int CAPACITY   = bpq_pkg::CAPACITY_DEF,
    parameter int ELEM_WIDTH = bpq_pkg::ELEM_WIDTH_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Operation stream
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: element [31:0], priority_req [35:32], zero pad [39:36]
    input  logic [bpq_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: mode [0]
    input  logic [0:0]                     s_tuser,
    // Result stream
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: head_element [31:0], head_priority [35:32], count [44:36],
    //          is_empty [45], zero pad [47:46]
    output logic [bpq_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: status [1:0]
    output logic [bpq_pkg::STATUS_FW-1:0]  m_tuser,
    // Configuration: lowest_level
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [bpq_pkg::PRIO_FW-1:0]    cfg_data
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int LW    = $clog2(LEVELS);
    localparam logic [CNT_W-1:0] CAP_COUNT = CNT_W'(CAPACITY);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_LINK = 6'b000100,
        S_DQN  = 6'b001000,
        S_READ = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    state_t                            state_reg, state_next;
    logic                              mode_reg, mode_next;
    logic [ELEM_WIDTH-1:0]             elem_reg, elem_next;
    logic [bpq_pkg::PRIO_FW-1:0]       prio_reg, prio_next;
    logic [bpq_pkg::PRIO_FW-1:0]       lowest_reg, lowest_next;
    logic [IDX_W-1:0]                  free_head_reg, free_head_next;
    logic [CNT_W-1:0]                  fresh_reg, fresh_next;
    logic [CNT_W-1:0]                  count_reg, count_next;
    bpq_pkg::status_t                  status_reg, status_next;
    logic [IDX_W-1:0]                  ptr_reg, ptr_next;
    logic [IDX_W-1:0]                  tail_save_reg, tail_save_next;
    logic [LW-1:0]                     level_save_reg, level_save_next;
    logic                              fh_load_reg, fh_load_next;
    logic                              m_valid_reg, m_valid_next;
    logic [bpq_pkg::M_TDATA_W-1:0]     m_data_reg, m_data_next;
    logic [bpq_pkg::STATUS_FW-1:0]     m_user_reg, m_user_next;

    // Cell command broadcast
    bpq_pkg::cell_op_t                 cell_op;
    logic [LW-1:0]                     cell_level;
    logic [IDX_W-1:0]                  cell_ptr;

    // Chains through the level cells
    logic                              ch_found [LEVELS+1];
    logic [LW-1:0]                     ch_level [LEVELS+1];
    logic [IDX_W-1:0]                  ch_head  [LEVELS+1];
    logic [IDX_W-1:0]                  ch_tail  [LEVELS+1];
    logic                              q_ne     [LEVELS+1];
    logic [IDX_W-1:0]                  q_tail   [LEVELS+1];
    logic [LW-1:0]                     q_level;

    // Entry store ports
    logic                              val_we, val_re, link_we, link_re;
    logic [IDX_W-1:0]                  val_waddr, val_raddr, link_waddr, link_raddr;
    logic [IDX_W-1:0]                  link_wdata, link_rdata;
    logic [ELEM_WIDTH-1:0]             val_rdata;

    logic                              in_accept, out_load;
    logic                              prio_ok, is_full, fresh_ok;
    logic [IDX_W-1:0]                  alloc_idx;
    logic                              head_found;
    logic [LW-1:0]                     head_level;
    logic [IDX_W-1:0]                  head_ptr, head_tail;
    logic [bpq_pkg::ELEM_FW-1:0]       out_elem;
    logic [bpq_pkg::PRIO_FW-1:0]       out_prio;

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;

    // Level cells: the chain start carries "nothing found yet".
    assign ch_found[0] = 1'b0;
    assign ch_level[0] = '0;
    assign ch_head[0]  = '0;
    assign ch_tail[0]  = '0;
    assign q_ne[0]     = 1'b0;
    assign q_tail[0]   = '0;
    assign q_level     = LW'(prio_reg);

    for (genvar i = 0; i < LEVELS; i++) begin : g_cell
        bpq_level_cell #(
            .IDX_W    (IDX_W),
            .LW       (LW),
            .LEVEL_ID (i)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .op_in      (cell_op),
            .op_level   (cell_level),
            .op_ptr     (cell_ptr),
            .found_in   (ch_found[i]),
            .level_in   (ch_level[i]),
            .head_in    (ch_head[i]),
            .tail_in    (ch_tail[i]),
            .found_out  (ch_found[i+1]),
            .level_out  (ch_level[i+1]),
            .head_out   (ch_head[i+1]),
            .tail_out   (ch_tail[i+1]),
            .q_level    (q_level),
            .q_ne_in    (q_ne[i]),
            .q_tail_in  (q_tail[i]),
            .q_ne_out   (q_ne[i+1]),
            .q_tail_out (q_tail[i+1])
        );
    end

    assign head_found = ch_found[LEVELS];
    assign head_level = ch_level[LEVELS];
    assign head_ptr   = ch_head[LEVELS];
    assign head_tail  = ch_tail[LEVELS];

    bpq_entry_store #(
        .DEPTH      (CAPACITY),
        .IDX_W      (IDX_W),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_store (
        .aclk        (aclk),
        .value_we    (val_we),
        .value_waddr (val_waddr),
        .value_wdata (elem_reg),
        .value_re    (val_re),
        .value_raddr (val_raddr),
        .value_rdata (val_rdata),
        .link_we     (link_we),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .link_re     (link_re),
        .link_raddr  (link_raddr),
        .link_rdata  (link_rdata)
    );

    // Admission checks and entry allocation.
    assign prio_ok   = (prio_reg <= lowest_reg) && (32'(prio_reg) < 32'(LEVELS));
    assign is_full   = (count_reg >= CAP_COUNT);
    assign fresh_ok  = (fresh_reg < CAP_COUNT);
    assign alloc_idx = fresh_ok ? fresh_reg[IDX_W-1:0] : free_head_reg;

    // Result fields as seen once the operation has settled.
    assign out_elem = head_found ? bpq_pkg::ELEM_FW'(val_rdata) : '0;
    assign out_prio = head_found ? bpq_pkg::PRIO_FW'(head_level) : '0;
    assign out_load = (state_reg == S_OUT) && (!m_valid_reg || m_tready);

    // Operation sequencer.
    always_comb begin
        state_next      = state_reg;
        mode_next       = mode_reg;
        elem_next       = elem_reg;
        prio_next       = prio_reg;
        lowest_next     = lowest_reg;
        free_head_next  = free_head_reg;
        fresh_next      = fresh_reg;
        count_next      = count_reg;
        status_next     = status_reg;
        ptr_next        = ptr_reg;
        tail_save_next  = tail_save_reg;
        level_save_next = level_save_reg;
        fh_load_next    = 1'b0;
        m_valid_next    = m_valid_reg & ~m_tready;
        m_data_next     = m_data_reg;
        m_user_next     = m_user_reg;
        cell_op         = bpq_pkg::OP_NONE;
        cell_level      = q_level;
        cell_ptr        = alloc_idx;
        val_we          = 1'b0;
        val_waddr       = alloc_idx;
        val_re          = 1'b0;
        val_raddr       = head_ptr;
        link_we         = 1'b0;
        link_waddr      = alloc_idx;
        link_wdata      = '0;
        link_re         = 1'b0;
        link_raddr      = free_head_reg;

        if (cfg_valid) begin
            lowest_next = cfg_data;
        end

        // A recycled entry's successor becomes the new free-list head.
        if (fh_load_reg) begin
            free_head_next = link_rdata;
        end

        case (state_reg)
            S_IDLE: begin
                if (in_accept) begin
                    mode_next  = s_tuser[0];
                    elem_next  = ELEM_WIDTH'(s_tdata[bpq_pkg::ELEM_FW-1:0]);
                    prio_next  = s_tdata[bpq_pkg::ELEM_FW +: bpq_pkg::PRIO_FW];
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                state_next  = S_READ;
                status_next = bpq_pkg::ST_OK;
                if (mode_reg == bpq_pkg::MODE_ENQ) begin
                    if (!prio_ok) begin
                        status_next = bpq_pkg::ST_RANGE;
                    end else if (is_full) begin
                        status_next = bpq_pkg::ST_FULL;
                    end else begin
                        // New entry with a zero link, appended to its level.
                        val_we  = 1'b1;
                        link_we = 1'b1;
                        if (fresh_ok) begin
                            fresh_next = fresh_reg + 1'b1;
                        end else begin
                            link_re      = 1'b1;
                            fh_load_next = 1'b1;
                        end
                        cell_op        = bpq_pkg::OP_PUSH;
                        count_next     = count_reg + 1'b1;
                        ptr_next       = alloc_idx;
                        tail_save_next = q_tail[LEVELS];
                        if (q_ne[LEVELS]) begin
                            state_next = S_LINK;
                        end
                    end
                end else begin
                    if ((count_reg == '0) || !head_found) begin
                        status_next = bpq_pkg::ST_EMPTY;
                    end else begin
                        // Head entry goes to the front of the free list.
                        link_we        = 1'b1;
                        link_waddr     = head_ptr;
                        link_wdata     = free_head_reg;
                        free_head_next = head_ptr;
                        count_next     = count_reg - 1'b1;
                        cell_level     = head_level;
                        if (head_tail == head_ptr) begin
                            cell_op = bpq_pkg::OP_POP_LAST;
                        end else begin
                            link_re         = 1'b1;
                            link_raddr      = head_ptr;
                            level_save_next = head_level;
                            state_next      = S_DQN;
                        end
                    end
                end
            end
            S_LINK: begin
                // Old tail points at the new entry.
                link_we    = 1'b1;
                link_waddr = tail_save_reg;
                link_wdata = ptr_reg;
                state_next = S_READ;
            end
            S_DQN: begin
                // The fetched successor becomes the level's head.
                cell_op    = bpq_pkg::OP_SET_HEAD;
                cell_level = level_save_reg;
                cell_ptr   = link_rdata;
                state_next = S_READ;
            end
            S_READ: begin
                val_re     = 1'b1;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {{bpq_pkg::M_PAD_W{1'b0}},
                                    (count_reg == '0),
                                    bpq_pkg::COUNT_FW'(count_reg),
                                    out_prio,
                                    out_elem};
                    m_user_next  = status_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state resets; payload registers are loaded before use.
    always_ff @(posedge aclk) begin
        mode_reg       <= mode_next;
        elem_reg       <= elem_next;
        prio_reg       <= prio_next;
        status_reg     <= status_next;
        ptr_reg        <= ptr_next;
        tail_save_reg  <= tail_save_next;
        level_save_reg <= level_save_next;
        m_data_reg     <= m_data_next;
        m_user_reg     <= m_user_next;
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            lowest_reg    <= bpq_pkg::LOWEST_LEVEL_RESET;
            free_head_reg <= '0;
            fresh_reg     <= '0;
            count_reg     <= '0;
            fh_load_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            lowest_reg    <= lowest_next;
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            count_reg     <= count_next;
            fh_load_reg   <= fh_load_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// ----- design/bpq_checker.sv -----
// ----------------------------------------------------------------------------
// Bucket priority queue port checker
// Watches the core's result port and flags results that are inconsistent
// over time.
// ----------------------------------------------------------------------------
module bpq_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [bpq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [bpq_pkg::STATUS_FW-1:0] m_tuser
);

    logic                            res_empty;
    logic [bpq_pkg::COUNT_FW-1:0]    res_count;
    logic [bpq_pkg::M_COUNT_LSB-1:0] res_head;

    assign res_empty = m_tdata[bpq_pkg::M_EMPTY_BIT];
    assign res_count = m_tdata[bpq_pkg::M_COUNT_LSB +: bpq_pkg::COUNT_FW];
    assign res_head  = m_tdata[bpq_pkg::M_COUNT_LSB-1:0];

    // No result may be offered in the cycle after reset.
    a_reset_clears : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result offered right after reset");

    // A stalled result transaction holds its contents.
    a_stall_holds : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

    // The empty flag agrees with the count.
    a_empty_count : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (res_empty == (res_count == '0)))
        else $error("empty flag disagrees with count");

    // An empty queue reports a zero head element and level.
    a_empty_head : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res_empty) |-> (res_head == '0))
        else $error("empty queue reports a head");

    // A rejected dequeue only happens on an empty queue.
    a_deq_empty : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser == bpq_pkg::ST_EMPTY)) |-> res_empty)
        else $error("dequeue rejected while elements are held");

endmodule

bind bucket_priority_queue_core bpq_checker u_bpq_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
